// ----- hw/rtl/eae_pkg.sv -----
// shared types and constants for the exponential adsr envelope generator
`default_nettype none

package eae_pkg;

    // register map indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK_FACTOR  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_FACTOR = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd5;

    // input item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_NOTE = 1'b1;

    // velocity and sustain are Q1.15
    localparam int FRAC_W   = 16;
    localparam int Q15_SHIFT = 15;
    localparam logic [FRAC_W-1:0] SUSTAIN_RESET = 16'h8000;

    // factors are multiplied in 16-bit slices, at most four of them
    localparam int SLICE_W = 16;
    localparam int CHUNK_W = 2;

    typedef enum logic [1:0] {
        MUL_DIFF_VEL  = 2'd0,
        MUL_PEAK_SUS  = 2'd1,
        MUL_LEVEL_FAC = 2'd2
    } mul_sel_t;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_TICK_MUL  = 8'b0000_0010,
        ST_TICK_ACC  = 8'b0000_0100,
        ST_TICK_DONE = 8'b0000_1000,
        ST_NOTE_MUL1 = 8'b0001_0000,
        ST_NOTE_PEAK = 8'b0010_0000,
        ST_NOTE_MUL2 = 8'b0100_0000,
        ST_NOTE_SUS  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic               capture;
        logic               note_off;
        mul_sel_t           mul_sel;
        logic [CHUNK_W-1:0] mul_chunk;
        logic               acc_init;
        logic               acc_add;
        logic [CHUNK_W-1:0] add_chunk;
        logic               peak_load;
        logic               note_done;
        logic               tick_done;
    } dp_cmd_t;

    typedef struct packed {
        logic in_op;
        logic in_vel_zero;
        logic out_full;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/eae_regs.sv -----
// configuration register file behind the apb port
`default_nettype none

module eae_regs
    import eae_pkg::*;
#(
    parameter int LEVEL_WIDTH  = 24,
    parameter int FACTOR_WIDTH = 32,
    parameter int PDATA_W      = 32,
    parameter int PADDR_W      = 5
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [PDATA_W-1:0]      pwdata,
    output logic      [PDATA_W-1:0]      prdata,
    output logic      [LEVEL_WIDTH-1:0]  min_level,
    output logic      [LEVEL_WIDTH-1:0]  max_level,
    output logic      [FACTOR_WIDTH-1:0] attack_factor,
    output logic      [FACTOR_WIDTH-1:0] decay_factor,
    output logic      [FACTOR_WIDTH-1:0] release_factor,
    output logic      [FRAC_W-1:0]       sustain_level
);

    localparam int ADDR_LSB = PADDR_W - REG_IDX_W;
    localparam logic [LEVEL_WIDTH-1:0]  LVL_ONE = LEVEL_WIDTH'(1) << (LEVEL_WIDTH - 2);
    localparam logic [FACTOR_WIDTH-1:0] FAC_ONE = FACTOR_WIDTH'(1) << (FACTOR_WIDTH - 2);

    logic [LEVEL_WIDTH-1:0]  min_level_reg, max_level_reg;
    logic [FACTOR_WIDTH-1:0] attack_reg, decay_reg, release_reg;
    logic [FRAC_W-1:0]       sustain_reg;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    wr_en;

    assign reg_idx = paddr[PADDR_W-1:ADDR_LSB];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= '0;
            max_level_reg <= LVL_ONE;
            attack_reg    <= FAC_ONE;
            decay_reg     <= FAC_ONE;
            release_reg   <= FAC_ONE;
            sustain_reg   <= SUSTAIN_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_LEVEL:      min_level_reg <= pwdata[LEVEL_WIDTH-1:0];
                REG_MAX_LEVEL:      max_level_reg <= pwdata[LEVEL_WIDTH-1:0];
                REG_ATTACK_FACTOR:  attack_reg    <= pwdata[FACTOR_WIDTH-1:0];
                REG_DECAY_FACTOR:   decay_reg     <= pwdata[FACTOR_WIDTH-1:0];
                REG_RELEASE_FACTOR: release_reg   <= pwdata[FACTOR_WIDTH-1:0];
                REG_SUSTAIN_LEVEL:  sustain_reg   <= pwdata[FRAC_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_LEVEL:      prdata = PDATA_W'(min_level_reg);
            REG_MAX_LEVEL:      prdata = PDATA_W'(max_level_reg);
            REG_ATTACK_FACTOR:  prdata = PDATA_W'(attack_reg);
            REG_DECAY_FACTOR:   prdata = PDATA_W'(decay_reg);
            REG_RELEASE_FACTOR: prdata = PDATA_W'(release_reg);
            REG_SUSTAIN_LEVEL:  prdata = PDATA_W'(sustain_reg);
            default:            prdata = '0;
        endcase
    end

    assign min_level      = min_level_reg;
    assign max_level      = max_level_reg;
    assign attack_factor  = attack_reg;
    assign decay_factor   = decay_reg;
    assign release_factor = release_reg;
    assign sustain_level  = sustain_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/eae_ctrl.sv -----
// sequencer that steps the datapath through ticks and note events
`default_nettype none

module eae_ctrl
    import eae_pkg::*;
#(
    parameter int FACTOR_WIDTH = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int NCHUNK = (FACTOR_WIDTH + SLICE_W - 1) / SLICE_W;
    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(NCHUNK - 1);

    state_t             state_reg, state_next;
    logic [CHUNK_W-1:0] cnt_reg, cnt_next;
    logic               accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.mul_sel   = MUL_LEVEL_FAC;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    if (status.in_op == OP_TICK)
                        state_next = ST_TICK_MUL;
                    else if (status.in_vel_zero)
                        cmd.note_off = 1'b1;
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_NOTE_MUL1;
                    end
                end
            end
            ST_TICK_MUL:
            begin
                cmd.mul_sel   = MUL_LEVEL_FAC;
                cmd.mul_chunk = cnt_reg;
                // first slice seeds the rounding term, later ones add the previous product
                if (cnt_reg == '0)
                    cmd.acc_init = 1'b1;
                else
                begin
                    cmd.acc_add   = 1'b1;
                    cmd.add_chunk = cnt_reg - CHUNK_W'(1);
                end
                if (cnt_reg == LAST_CHUNK)
                    state_next = ST_TICK_ACC;
                else
                    cnt_next = cnt_reg + CHUNK_W'(1);
            end
            ST_TICK_ACC:
            begin
                cmd.acc_add   = 1'b1;
                cmd.add_chunk = LAST_CHUNK;
                state_next    = ST_TICK_DONE;
            end
            ST_TICK_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.tick_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_NOTE_MUL1:
            begin
                cmd.mul_sel = MUL_DIFF_VEL;
                state_next  = ST_NOTE_PEAK;
            end
            ST_NOTE_PEAK:
            begin
                cmd.peak_load = 1'b1;
                state_next    = ST_NOTE_MUL2;
            end
            ST_NOTE_MUL2:
            begin
                cmd.mul_sel = MUL_PEAK_SUS;
                state_next  = ST_NOTE_SUS;
            end
            ST_NOTE_SUS:
            begin
                cmd.note_done = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/eae_dp.sv -----
// envelope datapath: shared slice multiplier, accumulator, level and target state, output register
`default_nettype none

module eae_dp
    import eae_pkg::*;
#(
    parameter int LEVEL_WIDTH  = 24,
    parameter int FACTOR_WIDTH = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_cmd_t                 cmd,
    output dp_status_t                   status,
    input  wire logic                    in_op,
    input  wire logic [FRAC_W-1:0]       in_velocity,
    input  wire logic [LEVEL_WIDTH-1:0]  min_level,
    input  wire logic [LEVEL_WIDTH-1:0]  max_level,
    input  wire logic [FACTOR_WIDTH-1:0] attack_factor,
    input  wire logic [FACTOR_WIDTH-1:0] decay_factor,
    input  wire logic [FACTOR_WIDTH-1:0] release_factor,
    input  wire logic [FRAC_W-1:0]       sustain_level,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [LEVEL_WIDTH-1:0]  out_sample,
    output logic                         out_active
);

    localparam int NCHUNK    = (FACTOR_WIDTH + SLICE_W - 1) / SLICE_W;
    localparam int FAC_PAD_W = SLICE_W * NCHUNK;
    localparam int ACC_W     = LEVEL_WIDTH + FAC_PAD_W;
    localparam int FAC_FRAC  = FACTOR_WIDTH - 2;
    localparam int R_W       = ACC_W - FAC_FRAC;
    localparam int PROD_W    = LEVEL_WIDTH + FRAC_W;
    localparam int Q_W       = PROD_W + 1 - Q15_SHIFT;
    localparam logic [LEVEL_WIDTH-1:0] LVL_MAX = '1;
    localparam logic [LEVEL_WIDTH-1:0] FLOOR   =
        LEVEL_WIDTH'((64'd1 << (LEVEL_WIDTH - 2)) / 100);
    localparam logic [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (FAC_FRAC - 1);
    localparam logic [PROD_W:0]   Q15_HALF = (PROD_W + 1)'(1) << (Q15_SHIFT - 1);

    logic [LEVEL_WIDTH-1:0] level_reg, target_now_reg, target_next_reg, peak_reg;
    logic                   releasing_reg;
    logic [FRAC_W-1:0]      vel_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic                   out_valid_reg, out_active_reg;
    logic [LEVEL_WIDTH-1:0] out_sample_reg;

    // shared multiplier operands
    logic                    diff_neg, go_up, go_down;
    logic [LEVEL_WIDTH-1:0]  diff_mag, mul_a;
    logic [FRAC_W-1:0]       mul_b;
    logic [FACTOR_WIDTH-1:0] fac_sel;
    logic [FAC_PAD_W-1:0]    fac_pad;
    logic [PROD_W-1:0]       prod;

    assign diff_neg = max_level < min_level;
    assign diff_mag = diff_neg ? (min_level - max_level) : (max_level - min_level);
    assign go_up    = level_reg < target_now_reg;
    assign go_down  = level_reg > target_now_reg;
    assign fac_sel  = go_up ? attack_factor : (releasing_reg ? release_factor : decay_factor);
    assign fac_pad  = FAC_PAD_W'(fac_sel);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DIFF_VEL:
            begin
                mul_a = diff_mag;
                mul_b = vel_reg;
            end
            MUL_PEAK_SUS:
            begin
                mul_a = peak_reg;
                mul_b = sustain_level;
            end
            default:
            begin
                mul_a = level_reg;
                mul_b = FRAC_W'(fac_pad >> (SLICE_W * cmd.mul_chunk));
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // q15 rounding of the registered product, shared by peak and sustain steps
    logic [PROD_W:0]      q_sum;
    logic [Q_W-1:0]       q_rnd;
    logic [LEVEL_WIDTH+2:0] pos_sum;
    logic [LEVEL_WIDTH-1:0] peak_val, sus_val;

    assign q_sum   = (PROD_W + 1)'(prod_reg) + Q15_HALF;
    assign q_rnd   = q_sum[PROD_W:Q15_SHIFT];
    assign pos_sum = (LEVEL_WIDTH + 3)'(min_level) + (LEVEL_WIDTH + 3)'(q_rnd);
    assign sus_val = (|q_rnd[Q_W-1:LEVEL_WIDTH]) ? LVL_MAX : q_rnd[LEVEL_WIDTH-1:0];

    always_comb
    begin
        if (!diff_neg)
            peak_val = (|pos_sum[LEVEL_WIDTH+2:LEVEL_WIDTH]) ? LVL_MAX
                                                             : pos_sum[LEVEL_WIDTH-1:0];
        else if (q_rnd > Q_W'(min_level))
            peak_val = '0;
        else
            peak_val = min_level - q_rnd[LEVEL_WIDTH-1:0];
    end

    // scaled level and the clamp toward the target
    logic [R_W-1:0]         r_full;
    logic [LEVEL_WIDTH-1:0] r_sat, level_upd;
    logic                   reached;

    assign r_full = acc_reg[ACC_W-1:FAC_FRAC];
    assign r_sat  = (|r_full[R_W-1:LEVEL_WIDTH]) ? LVL_MAX : r_full[LEVEL_WIDTH-1:0];

    always_comb
    begin
        reached   = 1'b0;
        level_upd = level_reg;
        if (go_up)
        begin
            reached   = r_sat >= target_now_reg;
            level_upd = reached ? target_now_reg : r_sat;
        end
        else if (go_down)
        begin
            reached   = r_sat <= target_now_reg;
            level_upd = reached ? target_now_reg : r_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (cmd.capture)
            vel_reg <= in_velocity;
        if (cmd.peak_load)
            peak_reg <= peak_val;
        if (cmd.acc_init)
            acc_reg <= ACC_HALF;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + (ACC_W'(prod_reg) << (SLICE_W * cmd.add_chunk));
        if (cmd.tick_done)
        begin
            out_sample_reg <= (level_upd > FLOOR) ? (level_upd - FLOOR) : '0;
            out_active_reg <= level_upd > FLOOR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= FLOOR;
            target_now_reg  <= FLOOR;
            target_next_reg <= FLOOR;
            releasing_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.note_off)
            begin
                target_now_reg  <= FLOOR;
                target_next_reg <= FLOOR;
                releasing_reg   <= 1'b1;
            end
            else if (cmd.note_done)
            begin
                target_now_reg  <= (peak_reg < FLOOR) ? FLOOR : peak_reg;
                target_next_reg <= (sus_val < FLOOR) ? FLOOR : sus_val;
                releasing_reg   <= 1'b0;
            end
            else if (cmd.tick_done)
            begin
                level_reg <= level_upd;
                if (reached)
                    target_now_reg <= target_next_reg;
            end

            if (cmd.tick_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.in_op       = in_op;
    assign status.in_vel_zero = (in_velocity == '0);
    assign status.out_full    = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_active = out_active_reg;

    a_target_now_floor: assert property (@(posedge clk) disable iff (!rst_n)
        target_now_reg >= FLOOR)
        else $error("current target below floor");

    a_target_next_floor: assert property (@(posedge clk) disable iff (!rst_n)
        target_next_reg >= FLOOR)
        else $error("next target below floor");

    a_active_matches_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_active_reg == (out_sample_reg != '0)))
        else $error("active flag disagrees with sample");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.tick_done)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ----- hw/rtl/exponential_adsr_envelope.sv -----
// top level of the exponential adsr envelope generator
`default_nettype none

// Exponential ADSR envelope generator. Requests enter on the s_ side: tuser selects a
// sample tick (0) or a note event (1), tdata carries the Q1.15 velocity. A sample tick
// holds the input through the slice multiply states, the accumulate state and the done
// state, whose exit registers its result: the level is multiplied by the selected Q2.30
// factor one 16-bit slice per cycle on a single shared multiplier, the last slice is
// added in, then the sum is rounded, saturated and clamped to the target. A note-on
// holds the input through its multiply, peak, multiply and sustain steps on the same
// multiplier (velocity scaling, then sustain scaling); a note-off is handled as it is
// accepted. Neither note event gives a result. s_tready is high only while no request
// is being worked on. The result of a tick is held in an output register, so the next
// request is taken while it waits; a tick that finishes while that register still holds
// an untaken result stays in its last step until m_tready frees it. m_tdata carries the
// level minus the 0.01 floor, m_tuser is high while the level is above the floor.
// Registers are written over the APB port; the user must write them only while the
// block is idle, the block itself does not enforce it.

module exponential_adsr_envelope
    import eae_pkg::*;
#(
    parameter int LEVEL_WIDTH  = 24,
    parameter int FACTOR_WIDTH = 32,
    localparam int PDATA_W  = (FACTOR_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W  = REG_IDX_W + ((FACTOR_WIDTH > 32) ? 3 : 2),
    localparam int MDATA_W  = ((LEVEL_WIDTH + 7) / 8) * 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [FRAC_W-1:0]  s_tdata,   // [15:0] velocity
    input  wire logic               s_tuser,   // [0] op
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [MDATA_W-1:0] m_tdata,   // [LEVEL_WIDTH-1:0] sample, rest zero
    output logic                    m_tuser    // [0] active
);

    logic [LEVEL_WIDTH-1:0]  min_level, max_level, out_sample;
    logic [FACTOR_WIDTH-1:0] attack_factor, decay_factor, release_factor;
    logic [FRAC_W-1:0]       sustain_level;
    dp_cmd_t                 cmd;
    dp_status_t              status;

    assign pready = 1'b1;

    eae_regs #(
        .LEVEL_WIDTH  (LEVEL_WIDTH),
        .FACTOR_WIDTH (FACTOR_WIDTH),
        .PDATA_W      (PDATA_W),
        .PADDR_W      (PADDR_W)
    ) u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .min_level      (min_level),
        .max_level      (max_level),
        .attack_factor  (attack_factor),
        .decay_factor   (decay_factor),
        .release_factor (release_factor),
        .sustain_level  (sustain_level)
    );

    eae_ctrl #(
        .FACTOR_WIDTH (FACTOR_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    eae_dp #(
        .LEVEL_WIDTH  (LEVEL_WIDTH),
        .FACTOR_WIDTH (FACTOR_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_op          (s_tuser),
        .in_velocity    (s_tdata),
        .min_level      (min_level),
        .max_level      (max_level),
        .attack_factor  (attack_factor),
        .decay_factor   (decay_factor),
        .release_factor (release_factor),
        .sustain_level  (sustain_level),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_sample     (out_sample),
        .out_active     (m_tuser)
    );

    assign m_tdata = MDATA_W'(out_sample);

endmodule

`default_nettype wire

// ----- tb/exponential_adsr_envelope_tb.sv -----
// testbench for the exponential adsr envelope generator: envelope predictor, drivers and checks
module exponential_adsr_envelope_tb
    import eae_pkg::*;
();

    localparam int CLK_HALF    = 6;
    localparam int LW          = 24;
    localparam int LATENCY_PAD = 10;
    localparam int LONG_HOLD   = 60;
    localparam logic [LW-1:0] LVL_FULL  = {LW{1'b1}};
    localparam logic [LW-1:0] FLOOR_LVL = 24'd41943;   // 0.01 in Q2.22

    typedef struct packed {
        logic [LW-1:0] sample;
        logic          active;
    } env_result_t;

    class envelope_scoreboard;
        logic [LW-1:0] min_lvl;
        logic [LW-1:0] max_lvl;
        logic [31:0]   atk_fac;
        logic [31:0]   dec_fac;
        logic [31:0]   rel_fac;
        logic [15:0]   sus_lvl;
        logic [LW-1:0] level;
        logic [LW-1:0] tgt_now;
        logic [LW-1:0] tgt_next;
        logic          releasing;
        env_result_t   due_samples[$];
        int            errors;
        int            reported;

        function new();
            min_lvl   = '0;
            max_lvl   = 24'h40_0000;
            atk_fac   = 32'h4000_0000;
            dec_fac   = 32'h4000_0000;
            rel_fac   = 32'h4000_0000;
            sus_lvl   = SUSTAIN_RESET;
            level     = FLOOR_LVL;
            tgt_now   = FLOOR_LVL;
            tgt_next  = FLOOR_LVL;
            releasing = 1'b0;
            errors    = 0;
            reported  = 0;
        endfunction

        function void mismatch(string msg);
            errors++;
            if (reported < 10)
            begin
                reported++;
                $display("mismatch: %s", msg);
            end
        endfunction

        // level * factor in Q2.30, rounded half up, saturated to full scale
        function logic [LW-1:0] scale(logic [LW-1:0] lv, logic [31:0] fac);
            logic [63:0] prod;
            prod = ({40'd0, lv} * {32'd0, fac} + 64'h2000_0000) >> 30;
            return (prod > {40'd0, LVL_FULL}) ? LVL_FULL : prod[LW-1:0];
        endfunction

        function logic [31:0] set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
            logic [31:0] kept;
            kept = '0;
            case (idx)
                REG_MIN_LEVEL:
                begin
                    min_lvl = val[LW-1:0];
                    kept    = {8'd0, min_lvl};
                end
                REG_MAX_LEVEL:
                begin
                    max_lvl = val[LW-1:0];
                    kept    = {8'd0, max_lvl};
                end
                REG_ATTACK_FACTOR:
                begin
                    atk_fac = val;
                    kept    = val;
                end
                REG_DECAY_FACTOR:
                begin
                    dec_fac = val;
                    kept    = val;
                end
                REG_RELEASE_FACTOR:
                begin
                    rel_fac = val;
                    kept    = val;
                end
                REG_SUSTAIN_LEVEL:
                begin
                    sus_lvl = val[15:0];
                    kept    = {16'd0, sus_lvl};
                end
                default: ;
            endcase
            return kept;
        endfunction

        function void take_request(logic op, logic [15:0] vel);
            logic [63:0] span;
            logic [63:0] rnd;
            logic [63:0] pk;
            logic [63:0] sv;
            env_result_t res;
            if (op == OP_NOTE)
            begin
                if (vel == 16'd0)
                begin
                    tgt_now   = FLOOR_LVL;
                    tgt_next  = FLOOR_LVL;
                    releasing = 1'b1;
                end
                else
                begin
                    // peak from velocity, rounded half away from zero
                    if (max_lvl >= min_lvl)
                    begin
                        span = {40'd0, max_lvl} - {40'd0, min_lvl};
                        rnd  = (span * {48'd0, vel} + 64'd16384) >> 15;
                        pk   = {40'd0, min_lvl} + rnd;
                    end
                    else
                    begin
                        span = {40'd0, min_lvl} - {40'd0, max_lvl};
                        rnd  = (span * {48'd0, vel} + 64'd16384) >> 15;
                        pk   = (rnd > {40'd0, min_lvl}) ? 64'd0 : {40'd0, min_lvl} - rnd;
                    end
                    if (pk > {40'd0, LVL_FULL})
                        pk = {40'd0, LVL_FULL};
                    sv = (pk * {48'd0, sus_lvl} + 64'd16384) >> 15;
                    if (sv > {40'd0, LVL_FULL})
                        sv = {40'd0, LVL_FULL};
                    tgt_now   = (pk[LW-1:0] < FLOOR_LVL) ? FLOOR_LVL : pk[LW-1:0];
                    tgt_next  = (sv[LW-1:0] < FLOOR_LVL) ? FLOOR_LVL : sv[LW-1:0];
                    releasing = 1'b0;
                end
            end
            else
            begin
                if (level < tgt_now)
                begin
                    level = scale(level, atk_fac);
                    if (level >= tgt_now)
                    begin
                        level   = tgt_now;
                        tgt_now = tgt_next;
                    end
                end
                else if (level > tgt_now)
                begin
                    level = scale(level, releasing ? rel_fac : dec_fac);
                    if (level <= tgt_now)
                    begin
                        level   = tgt_now;
                        tgt_now = tgt_next;
                    end
                end
                res.sample = (level > FLOOR_LVL) ? level - FLOOR_LVL : '0;
                res.active = (level > FLOOR_LVL);
                due_samples.push_back(res);
            end
        endfunction

        function void check_sample(logic [LW-1:0] sample, logic active);
            env_result_t want;
            if (due_samples.size() == 0)
                mismatch($sformatf("unexpected sample %h active %b", sample, active));
            else
            begin
                want = due_samples.pop_front();
                if (sample !== want.sample || active !== want.active)
                    mismatch($sformatf("sample exp %h got %h, active exp %b got %b",
                                       want.sample, sample, want.active, active));
            end
        endfunction

        function int pending();
            return due_samples.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [LW-1:0]      m_tdata;
    logic               m_tuser;

    bit                 calm = 1'b0;
    bit                 long_hold_req = 1'b0;
    int                 items_sent = 0;
    envelope_scoreboard sb;

    exponential_adsr_envelope u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] velocity
        .s_tuser  (s_tuser),    // [0] op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [23:0] sample
        .m_tuser  (m_tuser)     // [0] active
    );

    always #CLK_HALF clk = ~clk;

    task automatic send_item(logic op, logic [15:0] vel);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= vel;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_request(op, vel);
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 16'($urandom_range(0, 65535)));
    endtask

    // hold the input until every sample is back and the block has gone quiet
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic load_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        logic [31:0] kept;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        kept = sb.set_reg(idx, val);
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== kept)
            sb.mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, kept));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_all(logic [LW-1:0] lo, logic [LW-1:0] hi, logic [31:0] atk,
                            logic [31:0] dec, logic [31:0] rel, logic [15:0] sus);
        load_reg(REG_MIN_LEVEL, {8'd0, lo});
        load_reg(REG_MAX_LEVEL, {8'd0, hi});
        load_reg(REG_ATTACK_FACTOR, atk);
        load_reg(REG_DECAY_FACTOR, dec);
        load_reg(REG_RELEASE_FACTOR, rel);
        load_reg(REG_SUSTAIN_LEVEL, {16'd0, sus});
    endtask

    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'd1;
            2: return 16'($urandom_range(1, 65535));    // above 1.0 as well
            default: return 16'($urandom_range(1, 32768));
        endcase
    endfunction

    // note on, some ticks, usually a note off, some ticks; now and then broken up
    task automatic play_phrase();
        send_item(OP_NOTE, pick_velocity());
        repeat ($urandom_range(2, 40))
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_NOTE, 16'($urandom_range(0, 65535)));
            send_tick();
        end
        if ($urandom_range(0, 7) != 0)
            send_item(OP_NOTE, 16'd0);
        repeat ($urandom_range(2, 30)) send_tick();
    endtask

    task automatic load_random_config();
        logic [LW-1:0] lo;
        logic [LW-1:0] hi;
        lo = LW'($urandom_range(0, 24'h20_0000));
        hi = LW'($urandom_range(24'h10_0000, 24'hFF_FFFF));
        load_all(lo, hi,
                 $urandom_range(32'h4CCC_CCCC, 32'hC000_0000),
                 $urandom_range(32'h2000_0000, 32'h3CCC_CCCC),
                 $urandom_range(32'h1333_3333, 32'h3CCC_CCCC),
                 16'($urandom_range(328, 32768)));
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_sample(m_tdata[LW-1:0], m_tuser);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int phase_end[5];
        phase_end = '{130, 170, 290, 420, 550};
        sb = new();
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TICK;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unity factors, level never moves
        send_item(OP_TICK, 16'h0000);
        send_item(OP_NOTE, 16'h8000);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_NOTE, 16'h0000);
        send_item(OP_TICK, 16'hAAAA);
        wait_drained();

        // widest range, fastest attack, decay and release to zero, lowest sustain
        load_all(24'h00_0000, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                 16'd328);
        send_item(OP_NOTE, 16'hFFFF);
        repeat (6) send_tick();
        send_item(OP_NOTE, 16'h0001);
        send_tick();
        send_item(OP_NOTE, 16'h0000);
        wait_drained();

        // inverted range, decay and release that never fall, sustain above 1.0
        load_all(24'hFF_FFFF, 24'h00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000,
                 16'hFFFF);
        send_item(OP_NOTE, 16'h4000);
        repeat (5) send_tick();
        send_item(OP_NOTE, 16'h8000);
        send_tick();
        send_item(OP_NOTE, 16'h0000);
        send_tick();
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 1)
                // attack below 1.0 sinks the level, release above 1.0
                load_all(24'h00_0000, 24'hFF_FFFF, 32'h3000_0000, 32'h3F00_0000,
                         32'hFFFF_FFFF, 16'd32768);
            else
                load_random_config();
            if (ph == 4)
                calm = 1'b1;
            play_phrase();
            if (ph == 0)
                long_hold_req = 1'b1;   // output stalls while requests keep coming
            if (ph == 2)
                wait_drained();
            while (items_sent < phase_end[ph])
                play_phrase();
            wait_drained();
        end

        if (sb.errors == 0)
            $display("[exponential_adsr_envelope] OK");
        else
            $display("[exponential_adsr_envelope] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(2 * CLK_HALF * 200_000);
        $display("[exponential_adsr_envelope] ERROR");
        $finish;
    end

endmodule
